// ===== rtl/lcdseq_pkg.sv =====
`timescale 1ns / 1ps

package lcdseq_pkg;

    localparam int CmdW = 3;

    localparam logic [CmdW-1:0] CMD_CHAR    = 3'd0;
    localparam logic [CmdW-1:0] CMD_CLEAR   = 3'd1;
    localparam logic [CmdW-1:0] CMD_CURSPOS = 3'd2;
    localparam logic [CmdW-1:0] CMD_LINES   = 3'd3;
    localparam logic [CmdW-1:0] CMD_BLINK   = 3'd4;
    localparam logic [CmdW-1:0] CMD_DISPLAY = 3'd5;
    localparam logic [CmdW-1:0] CMD_CURSOR  = 3'd6;
    localparam logic [CmdW-1:0] CMD_SHIFT   = 3'd7;

    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    localparam logic [3:0] MAX_SHIFTS = 4'd10;

    localparam logic [7:0] INSTR_CLEAR       = 8'h01;
    localparam logic [7:0] INSTR_LINE1       = 8'h80;
    localparam logic [7:0] INSTR_LINE2       = 8'hC0;
    localparam logic [7:0] INSTR_SHIFT_RIGHT = 8'h1C;
    localparam logic [7:0] INSTR_SHIFT_LEFT  = 8'h18;
    localparam logic [7:0] BIT_LINES         = 8'h08;
    localparam logic [7:0] BIT_BLINK         = 8'h01;
    localparam logic [7:0] BIT_DISPLAY       = 8'h04;
    localparam logic [7:0] BIT_CURSOR        = 8'h03;
    localparam logic [7:0] DC_RESET          = 8'h0F;
    localparam logic [7:0] FS_RESET          = 8'h38;

    localparam logic [11:0] SETUP_8BIT  = 12'd30;
    localparam logic [11:0] SETUP_4BIT  = 12'd10;
    localparam logic [11:0] PULSE_RESET = 12'd100;

    localparam logic [2:0] ADDR_MODE  = 3'd0;
    localparam logic [2:0] ADDR_PULSE = 3'd4;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [1:0] phase;
        logic       nib_low;
        logic       last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic wide_bus;
    } t_dp_status;

endpackage

// ===== rtl/lcdseq_ctrl.sv =====
`timescale 1ns / 1ps

module lcdseq_ctrl import lcdseq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [CmdW-1:0] i_command,
    input  logic [3:0]      i_shift_count,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  t_dp_status      i_status,
    output t_ctrl_cmd       o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic       r_state, n_state;
    logic [3:0] r_bytes_left, n_bytes_left;
    logic [1:0] r_phase, n_phase;
    logic       r_nib_low, n_nib_low;
    logic       r_out_valid, n_out_valid;

    logic       accept;
    logic       out_free;
    logic       byte_done;
    logic       last_event;
    logic [3:0] req_bytes;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign byte_done   = (r_phase == PH_HOLD) && (i_status.wide_bus || r_nib_low);
    assign last_event  = byte_done && (r_bytes_left == 4'd1);

    always_comb begin
        if (i_command == CMD_SHIFT) begin
            req_bytes = (i_shift_count > MAX_SHIFTS) ? MAX_SHIFTS : i_shift_count;
        end else begin
            req_bytes = 4'd1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_bytes_left = r_bytes_left;
        n_phase      = r_phase;
        n_nib_low    = r_nib_low;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.load    = accept;
        o_cmd.emit    = 1'b0;
        o_cmd.phase   = r_phase;
        o_cmd.nib_low = r_nib_low;
        o_cmd.last    = last_event;
        case (r_state)
            S_IDLE: begin
                if (accept && (req_bytes != 4'd0)) begin
                    n_state      = S_RUN;
                    n_bytes_left = req_bytes;
                    n_phase      = PH_SETUP;
                    n_nib_low    = 1'b0;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_phase != PH_HOLD) begin
                        n_phase = r_phase + 2'd1;
                    end else begin
                        n_phase = PH_SETUP;
                        if (byte_done) begin
                            n_nib_low    = 1'b0;
                            n_bytes_left = r_bytes_left - 4'd1;
                            if (last_event) begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_nib_low = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bytes_left <= 4'd0;
            r_phase      <= PH_SETUP;
            r_nib_low    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bytes_left <= n_bytes_left;
            r_phase      <= n_phase;
            r_nib_low    <= n_nib_low;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

// ===== rtl/lcdseq_dp.sv =====
`timescale 1ns / 1ps

module lcdseq_dp import lcdseq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic [CmdW-1:0] i_command,
    input  logic [7:0]      i_char_code,
    input  logic [1:0]      i_row,
    input  logic [4:0]      i_col,
    input  logic            i_flag,
    input  t_ctrl_cmd       i_cmd,
    output t_dp_status      o_status,
    output logic            o_reg_select,
    output logic [3:0]      o_bus_high,
    output logic [3:0]      o_bus_low,
    output logic            o_low_driven,
    output logic            o_enable,
    output logic [11:0]     o_hold_cycles,
    output logic            o_last
);

    logic        r_wide_bus;
    logic [11:0] r_pulse_width;
    logic [7:0]  r_display_control, n_display_control;
    logic [7:0]  r_function_set, n_function_set;
    logic [7:0]  r_byte, n_byte;
    logic        r_rs, n_rs;

    logic        r_reg_select;
    logic [3:0]  r_bus_high;
    logic [3:0]  r_bus_low;
    logic        r_low_driven;
    logic        r_enable;
    logic [11:0] r_hold_cycles;
    logic        r_last;

    logic        cfg_write;
    logic [7:0]  dc_bit;
    logic [7:0]  col_addr;
    logic [3:0]  ev_high;
    logic [3:0]  ev_low;
    logic [11:0] ev_hold;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {20'd0, r_pulse_width} : {31'd0, r_wide_bus};
    assign o_status.wide_bus = r_wide_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_bus    <= 1'b0;
            r_pulse_width <= PULSE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == ADDR_PULSE[2]) begin
                r_pulse_width <= pwdata[11:0];
            end else begin
                r_wide_bus <= pwdata[0];
            end
        end
    end

    assign col_addr = {4'd0, i_col[3:0] - 4'd1};

    always_comb begin
        case (i_command)
            CMD_BLINK:   dc_bit = BIT_BLINK;
            CMD_DISPLAY: dc_bit = BIT_DISPLAY;
            default:     dc_bit = BIT_CURSOR;
        endcase
    end

    always_comb begin
        n_display_control = r_display_control;
        n_function_set    = r_function_set;
        n_rs              = 1'b0;
        case (i_command)
            CMD_CHAR: begin
                n_rs   = 1'b1;
                n_byte = i_char_code;
            end
            CMD_CLEAR: begin
                n_byte = INSTR_CLEAR;
            end
            CMD_CURSPOS: begin
                n_byte = col_addr | ((i_row == 2'd1) ? INSTR_LINE1 : INSTR_LINE2);
            end
            CMD_LINES: begin
                n_function_set = i_flag ? (r_function_set | BIT_LINES)
                                        : (r_function_set & ~BIT_LINES);
                n_byte = n_function_set;
            end
            CMD_BLINK, CMD_DISPLAY, CMD_CURSOR: begin
                n_display_control = i_flag ? (r_display_control | dc_bit)
                                           : (r_display_control & ~dc_bit);
                n_byte = n_display_control;
            end
            default: begin
                n_byte = i_flag ? INSTR_SHIFT_RIGHT : INSTR_SHIFT_LEFT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_control <= DC_RESET;
            r_function_set    <= FS_RESET;
        end else if (i_cmd.load) begin
            r_display_control <= n_display_control;
            r_function_set    <= n_function_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= n_byte;
            r_rs   <= n_rs;
        end
    end

    always_comb begin
        if (r_wide_bus) begin
            ev_high = r_byte[7:4];
            ev_low  = r_byte[3:0];
        end else begin
            ev_high = i_cmd.nib_low ? r_byte[3:0] : r_byte[7:4];
            ev_low  = 4'd0;
        end
        case (i_cmd.phase)
            PH_SETUP:  ev_hold = r_wide_bus ? SETUP_8BIT : SETUP_4BIT;
            PH_STROBE: ev_hold = r_pulse_width;
            default:   ev_hold = 12'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_reg_select  <= r_rs;
            r_bus_high    <= ev_high;
            r_bus_low     <= ev_low;
            r_low_driven  <= r_wide_bus;
            r_enable      <= (i_cmd.phase == PH_STROBE);
            r_hold_cycles <= ev_hold;
            r_last        <= i_cmd.last;
        end
    end

    assign o_reg_select  = r_reg_select;
    assign o_bus_high    = r_bus_high;
    assign o_bus_low     = r_bus_low;
    assign o_low_driven  = r_low_driven;
    assign o_enable      = r_enable;
    assign o_hold_cycles = r_hold_cycles;
    assign o_last        = r_last;

endmodule

// ===== rtl/char_lcd_command_sequencer.sv =====
`timescale 1ns / 1ps
// Character LCD command sequencer. A request arrives on the input channel
// (i_in_valid / o_in_ready) and is turned into a run of bus events on the
// output channel (o_out_valid / i_out_ready), one event per transfer, with
// o_last marking the final event of the request. Each byte gives three events
// (setup, E high, E low); in 4-bit mode the high nibble and then the low nibble
// go out, so a byte gives six events. A shift request gives up to ten bytes.
// The request is registered in the controller state, and the first event then
// goes into the output register; further events follow while the receiver
// keeps i_out_ready high. The byte counter in the controller handles one
// request at a time: a new request is taken once the last event of the
// previous one sits in the output register.
// A shift request with a count of zero gives no events.
// When the receiver stalls, the output register holds its event and the
// controller waits. Reset clears the channels, sets display control to 0x0F,
// function set to 0x38, 4-bit mode and the E pulse width register to 100.
// Registers on the APB port: bus width (1 for eight data lines) at 0x0,
// E pulse width at 0x4.

module char_lcd_command_sequencer import lcdseq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [CmdW-1:0] i_command,
    input  logic [7:0]      i_char_code,
    input  logic [1:0]      i_row,
    input  logic [4:0]      i_col,
    input  logic            i_flag,
    input  logic [3:0]      i_shift_count,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_reg_select,
    output logic [3:0]      o_bus_high,
    output logic [3:0]      o_bus_low,
    output logic            o_low_driven,
    output logic            o_enable,
    output logic [11:0]     o_hold_cycles,
    output logic            o_last
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    lcdseq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_shift_count (i_shift_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (dp_status),
        .o_cmd         (ctrl_cmd)
    );

    lcdseq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_flag        (i_flag),
        .i_cmd         (ctrl_cmd),
        .o_status      (dp_status),
        .o_reg_select  (o_reg_select),
        .o_bus_high    (o_bus_high),
        .o_bus_low     (o_bus_low),
        .o_low_driven  (o_low_driven),
        .o_enable      (o_enable),
        .o_hold_cycles (o_hold_cycles),
        .o_last        (o_last)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lcdseq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_AT       = 300;
    localparam int STALL_CYCLES   = 400;

    typedef struct packed {
        logic [CmdW-1:0] cmd;
        logic [7:0]      ch;
        logic [1:0]      row;
        logic [4:0]      col;
        logic            flag;
        logic [3:0]      cnt;
    } t_lcd_request;

    typedef struct packed {
        logic        rs;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic        drv;
        logic        en;
        logic [11:0] hold;
        logic        last;
    } t_bus_event;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;
    logic            in_valid = 1'b0;
    logic            o_in_ready;
    logic [CmdW-1:0] in_cmd = '0;
    logic [7:0]      in_ch = '0;
    logic [1:0]      in_row = '0;
    logic [4:0]      in_col = '0;
    logic            in_flag = 1'b0;
    logic [3:0]      in_cnt = '0;
    logic            o_out_valid;
    logic            out_ready = 1'b0;
    logic            o_reg_select;
    logic [3:0]      o_bus_high;
    logic [3:0]      o_bus_low;
    logic            o_low_driven;
    logic            o_enable;
    logic [11:0]     o_hold_cycles;
    logic            o_last;

    logic            quiet = 1'b0;
    t_lcd_request    req_pending[$];
    t_bus_event      bus_expect[$];
    int              errors = 0;

    logic [7:0]      dc_shadow = DC_RESET;
    logic [7:0]      fs_shadow = FS_RESET;
    logic            cfg_mode8 = 1'b0;
    logic [11:0]     cfg_pulse = PULSE_RESET;

    char_lcd_command_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (in_cmd),
        .i_char_code   (in_ch),
        .i_row         (in_row),
        .i_col         (in_col),
        .i_flag        (in_flag),
        .i_shift_count (in_cnt),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_reg_select  (o_reg_select),
        .o_bus_high    (o_bus_high),
        .o_bus_low     (o_bus_low),
        .o_low_driven  (o_low_driven),
        .o_enable      (o_enable),
        .o_hold_cycles (o_hold_cycles),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_strobe(logic rs, logic [3:0] hi, logic [3:0] lo,
                                        logic drv, logic [11:0] setup);
        bus_expect.push_back('{rs, hi, lo, drv, 1'b0, setup, 1'b0});
        bus_expect.push_back('{rs, hi, lo, drv, 1'b1, cfg_pulse, 1'b0});
        bus_expect.push_back('{rs, hi, lo, drv, 1'b0, 12'd0, 1'b0});
    endfunction

    function automatic int push_byte(logic rs, logic [7:0] b);
        if (cfg_mode8) begin
            push_strobe(rs, b[7:4], b[3:0], 1'b1, SETUP_8BIT);
            return 3;
        end
        push_strobe(rs, b[7:4], 4'h0, 1'b0, SETUP_4BIT);
        push_strobe(rs, b[3:0], 4'h0, 1'b0, SETUP_4BIT);
        return 6;
    endfunction

    function automatic void predict_bus_events(t_lcd_request r);
        int         n;
        logic [4:0] col_m1;
        logic [7:0] b;
        logic [3:0] shifts;
        n = 0;
        case (r.cmd)
            CMD_CHAR: begin
                n = push_byte(1'b1, r.ch);
            end
            CMD_CLEAR: begin
                n = push_byte(1'b0, INSTR_CLEAR);
            end
            CMD_CURSPOS: begin
                col_m1 = r.col - 5'd1;
                b = {4'h0, col_m1[3:0]} | ((r.row == 2'd1) ? INSTR_LINE1 : INSTR_LINE2);
                n = push_byte(1'b0, b);
            end
            CMD_LINES: begin
                fs_shadow = r.flag ? (fs_shadow | BIT_LINES) : (fs_shadow & ~BIT_LINES);
                n = push_byte(1'b0, fs_shadow);
            end
            CMD_BLINK, CMD_DISPLAY, CMD_CURSOR: begin
                b = (r.cmd == CMD_BLINK) ? BIT_BLINK :
                    ((r.cmd == CMD_DISPLAY) ? BIT_DISPLAY : BIT_CURSOR);
                dc_shadow = r.flag ? (dc_shadow | b) : (dc_shadow & ~b);
                n = push_byte(1'b0, dc_shadow);
            end
            default: begin
                shifts = (r.cnt > MAX_SHIFTS) ? MAX_SHIFTS : r.cnt;
                b = r.flag ? INSTR_SHIFT_RIGHT : INSTR_SHIFT_LEFT;
                for (int i = 0; i < shifts; i++) begin
                    n += push_byte(1'b0, b);
                end
            end
        endcase
        if (n > 0) begin
            bus_expect[bus_expect.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void show_event(string tag, t_bus_event e);
        $display("%0t: %s rs=%0b hi=%h lo=%h drv=%0b en=%0b hold=%0d last=%0b",
                 $time, tag, e.rs, e.hi, e.lo, e.drv, e.en, e.hold, e.last);
    endfunction

    always @(posedge i_clk) begin : request_driver
        t_lcd_request r;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (req_pending.size() != 0 && (quiet || $urandom_range(0, 99) >= 22)) begin
                r = req_pending.pop_front();
                in_valid <= 1'b1;
                in_cmd   <= r.cmd;
                in_ch    <= r.ch;
                in_row   <= r.row;
                in_col   <= r.col;
                in_flag  <= r.flag;
                in_cnt   <= r.cnt;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    int rx_count = 0;
    int stall_left = 0;
    logic stall_done = 1'b0;

    always @(posedge i_clk) begin : bus_receiver
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                rx_count <= rx_count + 1;
            end
            if (!stall_done && rx_count >= STALL_AT) begin
                stall_done <= 1'b1;
                stall_left <= STALL_CYCLES;
                out_ready  <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= quiet || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    always @(posedge i_clk) begin : bus_monitor
        t_bus_event got;
        t_bus_event want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                predict_bus_events('{in_cmd, in_ch, in_row, in_col, in_flag, in_cnt});
            end
            if (o_out_valid && out_ready) begin
                got = '{o_reg_select, o_bus_high, o_bus_low, o_low_driven, o_enable,
                        o_hold_cycles, o_last};
                if (bus_expect.size() == 0) begin
                    errors++;
                    $display("%0t: expected no bus event", $time);
                    show_event("actual  ", got);
                end else begin
                    want = bus_expect.pop_front();
                    if (got !== want) begin
                        errors++;
                        show_event("expected", want);
                        show_event("actual  ", got);
                    end
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODE) begin
            cfg_mode8 = data[0];
        end else if (addr == ADDR_PULSE) begin
            cfg_pulse = data[11:0];
        end
    endtask

    task automatic add_req(logic [CmdW-1:0] cmd, logic [7:0] ch, logic [1:0] row,
                           logic [4:0] col, logic flag, logic [3:0] cnt);
        req_pending.push_back('{cmd, ch, row, col, flag, cnt});
    endtask

    task automatic add_random(int count);
        t_lcd_request r;
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            r.cmd  = CmdW'($urandom_range(0, 7));
            r.ch   = 8'($urandom);
            r.row  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                 : 2'($urandom_range(1, 2));
            r.col  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
            r.flag = 1'($urandom);
            r.cnt  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 4));
            req_pending.push_back(r);
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (req_pending.size() != 0 || in_valid || bus_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        add_req(CMD_CHAR,    8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        add_req(CMD_CHAR,    8'hFF, 2'd2, 5'd16, 1'b1, 4'd15);
        add_req(CMD_CLEAR,   8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        add_req(CMD_CURSPOS, 8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        add_req(CMD_CURSPOS, 8'h00, 2'd2, 5'd16, 1'b0, 4'd0);
        add_req(CMD_CURSPOS, 8'h00, 2'd0, 5'd0,  1'b0, 4'd0);
        add_req(CMD_CURSPOS, 8'h00, 2'd3, 5'd31, 1'b0, 4'd0);
        add_req(CMD_LINES,   8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        add_req(CMD_LINES,   8'h00, 2'd1, 5'd1,  1'b1, 4'd0);
        add_req(CMD_BLINK,   8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        add_req(CMD_BLINK,   8'h00, 2'd1, 5'd1,  1'b1, 4'd0);
        add_req(CMD_DISPLAY, 8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        add_req(CMD_DISPLAY, 8'h00, 2'd1, 5'd1,  1'b1, 4'd0);
        add_req(CMD_CURSOR,  8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        add_req(CMD_CURSOR,  8'h00, 2'd1, 5'd1,  1'b1, 4'd0);
        add_req(CMD_SHIFT,   8'h00, 2'd1, 5'd1,  1'b0, 4'd1);
        add_req(CMD_SHIFT,   8'h00, 2'd1, 5'd1,  1'b1, 4'd10);
        add_req(CMD_SHIFT,   8'h00, 2'd1, 5'd1,  1'b1, 4'd15);
        add_req(CMD_SHIFT,   8'h00, 2'd1, 5'd1,  1'b0, 4'd0);
        wait_drained();

        cfg_write(ADDR_MODE, 32'd1);
        cfg_write(ADDR_PULSE, 32'd1);
        add_random(120);
        wait_drained();

        cfg_write(ADDR_PULSE, 32'd4095);
        quiet <= 1'b1;
        add_random(120);
        wait_drained();
        quiet <= 1'b0;

        cfg_write(ADDR_MODE, 32'd0);
        cfg_write(ADDR_PULSE, 32'd0);
        add_random(110);
        wait_drained();

        cfg_write(ADDR_MODE, 32'd1);
        cfg_write(ADDR_PULSE, 32'($urandom_range(2, 4094)));
        add_random(100);
        wait_drained();

        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0 && bus_expect.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lcdseq_pkg.sv
rtl/lcdseq_ctrl.sv
rtl/lcdseq_dp.sv
rtl/char_lcd_command_sequencer.sv
tb/sv/tb.sv
